>>> sv/prmp_pkg.sv
// Shared types, constants and helper functions of the ramp motion profile block.
package prmp_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int SEG_OUT_W    = 6;
  localparam int SUM_W        = 51;
  localparam int Q_W          = 49;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_PAST = 2'd2;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] CFG_START_ANGLE = 2'd0;
  localparam logic [1:0] CFG_START_SPEED = 2'd1;
  localparam logic [1:0] CFG_SPEED_EPS   = 2'd2;

  typedef struct packed {
    logic               command;
    logic [31:0]        seg_duration;
    logic signed [31:0] seg_accel;
    logic [31:0]        query_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic signed [31:0]   angle_out;
    logic signed [31:0]   speed_out;
    logic [SEG_OUT_W-1:0] segment_index;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        end_time;
    logic signed [31:0] end_angle;
    logic signed [31:0] end_speed;
    logic signed [31:0] accel;
  } seg_entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_ADD_LAST, S_Q_LAST, S_CHK_C, S_CHK_P, S_WALK,
    S_F_CUR, S_F_PREV, S_E1, S_E2, S_E3, S_E4, S_E5, S_E6
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LATCH, OP_RES_FULL, OP_RES_EMPTY, OP_RES_PAST, OP_RD_LAST,
    OP_BASE_START, OP_BASE_MEM, OP_RD_CACHE, OP_RD_NEXT, OP_RD_PREV,
    OP_RD_ZERO, OP_RD_C, OP_CUR, OP_BASE_PREV, OP_MUL_A, OP_MUL_LO,
    OP_MUL_HI, OP_MUL_V, OP_SUM, OP_FINISH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic is_add;
    logic full;
    logic empty;
    logic t_ge_rd;
    logic rd_lt_t;
    logic c_zero;
    logic c_last;
    logic out_free;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] r;
    if (v > SUM_W'(signed'(32'sh7FFFFFFF))) r = 32'sh7FFFFFFF;
    else if (v < SUM_W'(signed'(32'sh80000000))) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] s);
    logic [31:0] r;
    if (s[31]) r = 32'(-s);
    else r = s;
    return r;
  endfunction

endpackage

>>> sv/prmp_ctrl.sv
// Controller state machine: sequences reads, the segment search and the evaluation steps.
module prmp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  prmp_pkg::sts_t sts,
  output prmp_pkg::cmd_t cmd
);
  import prmp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_START;
      S_START: begin
        if (sts.is_add) begin
          if (sts.full) begin
            if (sts.out_free) state_next = S_IDLE;
          end else if (sts.empty) state_next = S_E1;
          else state_next = S_ADD_LAST;
        end else begin
          if (sts.empty) begin
            if (sts.out_free) state_next = S_IDLE;
          end else state_next = S_Q_LAST;
        end
      end
      S_ADD_LAST: state_next = S_E1;
      S_Q_LAST: begin
        if (sts.t_ge_rd) begin
          if (sts.out_free) state_next = S_IDLE;
        end else state_next = S_CHK_C;
      end
      S_CHK_C: begin
        if (sts.rd_lt_t) state_next = S_WALK;
        else if (!sts.c_zero) state_next = S_CHK_P;
        else state_next = S_F_CUR;
      end
      S_CHK_P: state_next = sts.t_ge_rd ? S_F_CUR : S_WALK;
      S_WALK: if (sts.c_last || !sts.rd_lt_t) state_next = S_F_CUR;
      S_F_CUR: state_next = sts.c_zero ? S_E1 : S_F_PREV;
      S_F_PREV: state_next = S_E1;
      S_E1: state_next = S_E2;
      S_E2: state_next = S_E3;
      S_E3: state_next = S_E4;
      S_E4: state_next = S_E5;
      S_E5: state_next = S_E6;
      S_E6: if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NOP;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd.op = OP_LATCH;
      end
      S_START: begin
        if (sts.is_add) begin
          if (sts.full) begin
            if (sts.out_free) cmd.op = OP_RES_FULL;
          end else if (sts.empty) cmd.op = OP_BASE_START;
          else cmd.op = OP_RD_LAST;
        end else begin
          if (sts.empty) begin
            if (sts.out_free) cmd.op = OP_RES_EMPTY;
          end else cmd.op = OP_RD_LAST;
        end
      end
      S_ADD_LAST: cmd.op = OP_BASE_MEM;
      S_Q_LAST: begin
        if (sts.t_ge_rd) begin
          if (sts.out_free) cmd.op = OP_RES_PAST;
        end else cmd.op = OP_RD_CACHE;
      end
      S_CHK_C: begin
        if (sts.rd_lt_t) cmd.op = OP_RD_NEXT;
        else if (!sts.c_zero) cmd.op = OP_RD_PREV;
        else cmd.op = OP_RD_C;
      end
      S_CHK_P: cmd.op = sts.t_ge_rd ? OP_RD_C : OP_RD_ZERO;
      S_WALK: cmd.op = (sts.c_last || !sts.rd_lt_t) ? OP_RD_C : OP_RD_NEXT;
      S_F_CUR: cmd.op = OP_CUR;
      S_F_PREV: cmd.op = OP_BASE_PREV;
      S_E1: cmd.op = OP_MUL_A;
      S_E2: cmd.op = OP_MUL_LO;
      S_E3: cmd.op = OP_MUL_HI;
      S_E4: cmd.op = OP_MUL_V;
      S_E5: cmd.op = OP_SUM;
      S_E6: if (sts.out_free) cmd.op = OP_FINISH;
      default: cmd.op = OP_NOP;
    endcase
  end

endmodule

>>> sv/prmp_dp.sv
// Datapath: segment memory, configuration, shared multiplier, sums and the output register.
module prmp_dp (
  input  logic                clk,
  input  logic                rst,
  input  prmp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output prmp_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  prmp_pkg::cmd_t      cmd,
  output prmp_pkg::sts_t      sts
);
  import prmp_pkg::*;

  seg_entry_t mem [MAX_SEGMENTS];
  seg_entry_t rd;
  logic       rd_en;
  logic [IDX_W-1:0] rd_addr;

  in_item_t item;
  logic [CNT_W-1:0] n;
  logic [IDX_W-1:0] cache, c;
  logic signed [31:0] start_angle, start_speed;
  logic [30:0] speed_eps;

  logic signed [31:0] a0, v0, acc;
  logic [31:0] dt, t_end;
  logic [63:0] prod, m, lo;
  logic [Q_W-1:0] q;
  logic signed [SUM_W-1:0] ang_w, spd_w;

  logic [31:0] mul_a;
  logic [32:0] te_sum;
  logic [64:0] q_sum;
  logic [63:0] q_half;
  logic [CNT_W-1:0] c_ext;
  logic signed [SUM_W-1:0] vt_s, q_s, at_s;
  logic signed [31:0] ang_s, spd_s, spd_f;
  logic mem_we;
  logic out_load;

  assign c_ext = CNT_W'(c);
  assign sts.is_add   = (item.command == CMD_ADD);
  assign sts.full     = (n == CNT_W'(MAX_SEGMENTS));
  assign sts.empty    = (n == '0);
  assign sts.t_ge_rd  = (item.query_time >= rd.end_time);
  assign sts.rd_lt_t  = (rd.end_time < item.query_time);
  assign sts.c_zero   = (c == '0);
  assign sts.c_last   = (c_ext + CNT_W'(1) >= n);
  assign sts.out_free = !out_valid || !out_stall;

  always_comb begin
    rd_en = 1'b1;
    rd_addr = c;
    case (cmd.op)
      OP_RD_LAST:  rd_addr = IDX_W'(n - CNT_W'(1));
      OP_RD_CACHE: rd_addr = (CNT_W'(cache) >= n) ? '0 : cache;
      OP_RD_NEXT:  rd_addr = sts.c_last ? c : IDX_W'(c_ext + CNT_W'(1));
      OP_RD_PREV,
      OP_CUR:      rd_addr = c - IDX_W'(1);
      OP_RD_ZERO:  rd_addr = '0;
      OP_RD_C:     rd_addr = c;
      default:     rd_en = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd.op)
      OP_MUL_A:  mul_a = mag32(acc);
      OP_MUL_LO: mul_a = prod[31:0];
      OP_MUL_HI: mul_a = m[63:32];
      default:   mul_a = mag32(v0);
    endcase
  end

  assign te_sum = {1'b0, rd.end_time} + {1'b0, item.seg_duration};
  assign q_sum  = {1'b0, prod} + {33'd0, lo[63:32]};
  assign q_half = q_sum[64:1];

  assign vt_s = v0[31] ? -SUM_W'(prod[63:16]) : SUM_W'(prod[63:16]);
  assign q_s  = acc[31] ? -SUM_W'(q) : SUM_W'(q);
  assign at_s = acc[31] ? -SUM_W'(m[63:16]) : SUM_W'(m[63:16]);

  assign ang_s = sat32(ang_w);
  assign spd_s = sat32(spd_w);
  assign spd_f = (sts.is_add && ({1'b0, mag32(spd_s)} < {2'b0, speed_eps})) ? '0 : spd_s;
  assign mem_we = (cmd.op == OP_FINISH) && sts.is_add;
  assign out_load = cmd.op inside {OP_RES_FULL, OP_RES_EMPTY, OP_RES_PAST, OP_FINISH};

  always_ff @(posedge clk) begin
    if (mem_we) mem[IDX_W'(n)] <= '{t_end, ang_s, spd_f, acc};
    if (rd_en) rd <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
      cache <= '0;
      c <= '0;
      out_valid <= 1'b0;
      start_angle <= '0;
      start_speed <= '0;
      speed_eps <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_ANGLE: start_angle <= cfg_data;
          CFG_START_SPEED: start_speed <= cfg_data;
          CFG_SPEED_EPS:   speed_eps <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (cmd.op)
        OP_LATCH: item <= in_data;
        OP_RES_FULL: begin
          out_data <= '{ST_FULL, 32'sd0, 32'sd0, '0};
        end
        OP_RES_EMPTY: begin
          out_data <= '{ST_PAST, start_angle, start_speed, '0};
        end
        OP_RES_PAST: begin
          out_data <= '{ST_PAST, rd.end_angle, rd.end_speed,
                        SEG_OUT_W'(n - CNT_W'(1))};
        end
        OP_BASE_START: begin
          a0 <= start_angle;
          v0 <= start_speed;
          acc <= item.seg_accel;
          dt <= item.seg_duration;
          t_end <= item.seg_duration;
        end
        OP_BASE_MEM: begin
          a0 <= rd.end_angle;
          v0 <= rd.end_speed;
          acc <= item.seg_accel;
          dt <= item.seg_duration;
          t_end <= te_sum[32] ? 32'hFFFF_FFFF : te_sum[31:0];
        end
        OP_RD_CACHE, OP_RD_NEXT, OP_RD_ZERO: c <= rd_addr;
        OP_CUR: begin
          acc <= rd.accel;
          cache <= c;
          if (c == '0) begin
            a0 <= start_angle;
            v0 <= start_speed;
            dt <= item.query_time;
          end
        end
        OP_BASE_PREV: begin
          a0 <= rd.end_angle;
          v0 <= rd.end_speed;
          dt <= sts.t_ge_rd ? item.query_time - rd.end_time : '0;
        end
        OP_MUL_A, OP_MUL_LO, OP_MUL_HI, OP_MUL_V: begin
          prod <= mul_a * dt;
          if (cmd.op == OP_MUL_LO) m <= prod;
          if (cmd.op == OP_MUL_HI) lo <= prod;
          if (cmd.op == OP_MUL_V) begin
            q <= (q_half > 64'(1) << 48) ? Q_W'(64'(1) << 48) : q_half[Q_W-1:0];
          end
        end
        OP_SUM: begin
          ang_w <= SUM_W'(a0) + vt_s + q_s;
          spd_w <= SUM_W'(v0) + at_s;
        end
        OP_FINISH: begin
          out_data <= '{ST_OK, ang_s, spd_f,
                        sts.is_add ? SEG_OUT_W'(n) : SEG_OUT_W'(c)};
          if (sts.is_add) n <= n + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

>>> sv/piecewise_ramp_motion_profile.sv
// Top level of the piecewise constant-acceleration motion profile block.
// Requests arrive on the in channel (in_valid, in_stall, in_data); an add request
// appends a segment, a query request evaluates angle and speed at a time.
// Every request gives exactly one result on the out channel (out_valid,
// out_stall, out_data), held in an output register until it is taken.
// One request is worked on at a time; in_stall is high while one is in flight.
// An add is evaluated in the four steps of the shared 32 by 32 multiplier, then
// the sum and the saturation; an add to a full table is answered from the start
// state without evaluation.
// A query at or past the end of the profile is answered from the last segment
// (the start registers on an empty table); inside the profile it searches from
// the cached segment, one segment memory read per step, and then evaluates.
// Results are only registered while the output register is free, so a stalled
// receiver holds the block in its last step without losing anything.
// Synchronous reset empties the segment table, clears the cached index and the
// configuration registers; the table contents need no clearing pass.
// Configuration writes (cfg_we, cfg_index, cfg_data) apply from the next cycle.
module piecewise_ramp_motion_profile (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  prmp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output prmp_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import prmp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  prmp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  prmp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> sv/prmp_chk.sv
// Port-level checker of the motion profile block and its bind.
module prmp_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input prmp_pkg::out_item_t out_data,
  input logic                out_valid,
  input logic                out_stall
);
  import prmp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("new request taken while one is in flight");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_FULL |->
      out_data.angle_out == 0 && out_data.speed_out == 0 && out_data.segment_index == 0)
    else $error("dropped segment result carries data");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status != 2'd3)
    else $error("undefined status code");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind piecewise_ramp_motion_profile prmp_chk u_prmp_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

>>> test/piecewise_ramp_motion_profile_tb.sv
// Self-checking testbench for the piecewise constant-acceleration motion profile block.
`timescale 1ns / 1ps

module piecewise_ramp_motion_profile_tb;
  import prmp_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_START_ANGLE;
  logic [31:0] cfg_data = '0;

  piecewise_ramp_motion_profile u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Profile predictor state.
  logic [31:0] seg_end_time [MAX_SEGMENTS];
  logic signed [31:0] seg_end_angle [MAX_SEGMENTS];
  logic signed [31:0] seg_end_speed [MAX_SEGMENTS];
  logic signed [31:0] seg_accel [MAX_SEGMENTS];
  int seg_count = 0;
  int seg_cache = 0;
  logic signed [31:0] cfg_angle0 = '0;
  logic signed [31:0] cfg_speed0 = '0;
  logic [30:0] cfg_eps = '0;

  in_item_t pending_requests[$];
  out_item_t expected_results[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  // Generator view of the table, so that query times can land on boundaries.
  logic [31:0] plan_bounds[$];
  logic [31:0] plan_total = '0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] magnitude(logic signed [31:0] s);
    return s < 0 ? 64'(-longint'(s)) : 64'(longint'(s));
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > longint'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
    if (v < -longint'(64'h80000000)) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint scale_q16(logic signed [31:0] s, logic [31:0] t);
    logic [63:0] r;
    r = (magnitude(s) * {32'b0, t}) >> 16;
    return s < 0 ? -longint'(r) : longint'(r);
  endfunction

  // Exact a*t*t/2^33 truncated toward zero, capped in magnitude at 2^48.
  function automatic longint ramp_term(logic signed [31:0] a, logic [31:0] t);
    logic [63:0] m, hi, lo, q;
    m = magnitude(a) * {32'b0, t};
    hi = (m >> 32) * {32'b0, t};
    lo = {32'b0, m[31:0]} * {32'b0, t};
    q = (hi + (lo >> 32)) >> 1;
    if (q > 64'h1_0000_0000_0000) q = 64'h1_0000_0000_0000;
    return a < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic out_item_t profile_step(in_item_t req);
    out_item_t r;
    int n, c;
    logic [31:0] t0, t, total;
    logic signed [31:0] a0, v0, ang, spd;
    logic [63:0] te;
    r = '0;
    n = seg_count;
    if (req.command == CMD_ADD) begin
      if (n >= MAX_SEGMENTS) begin
        r.status = ST_FULL;
      end else begin
        t0 = n ? seg_end_time[n-1] : 32'd0;
        a0 = n ? seg_end_angle[n-1] : cfg_angle0;
        v0 = n ? seg_end_speed[n-1] : cfg_speed0;
        te = {32'b0, t0} + {32'b0, req.seg_duration};
        ang = clamp32(longint'(a0) + scale_q16(v0, req.seg_duration)
                      + ramp_term(req.seg_accel, req.seg_duration));
        spd = clamp32(longint'(v0) + scale_q16(req.seg_accel, req.seg_duration));
        if (magnitude(spd) < {33'b0, cfg_eps}) spd = '0;
        seg_end_time[n] = te > 64'hFFFFFFFF ? 32'hFFFFFFFF : te[31:0];
        seg_end_angle[n] = ang;
        seg_end_speed[n] = spd;
        seg_accel[n] = req.seg_accel;
        seg_count = n + 1;
        r.status = ST_OK;
        r.angle_out = ang;
        r.speed_out = spd;
        r.segment_index = SEG_OUT_W'(n);
      end
    end else begin
      t = req.query_time;
      total = n ? seg_end_time[n-1] : 32'd0;
      if (n == 0 || t >= total) begin
        r.status = ST_PAST;
        r.angle_out = n ? seg_end_angle[n-1] : cfg_angle0;
        r.speed_out = n ? seg_end_speed[n-1] : cfg_speed0;
        r.segment_index = n ? SEG_OUT_W'(n - 1) : '0;
      end else begin
        c = seg_cache;
        if (c >= n) c = 0;
        if (seg_end_time[c] < t) begin
          c++;
          if (c >= n) c = n - 1;
        end else if (c != 0 && t < seg_end_time[c-1]) begin
          c = 0;
        end
        while (c + 1 < n && seg_end_time[c] < t) c++;
        seg_cache = c;
        t0 = c ? seg_end_time[c-1] : 32'd0;
        a0 = c ? seg_end_angle[c-1] : cfg_angle0;
        v0 = c ? seg_end_speed[c-1] : cfg_speed0;
        t0 = t >= t0 ? t - t0 : 32'd0;
        r.status = ST_OK;
        r.angle_out = clamp32(longint'(a0) + scale_q16(v0, t0) + ramp_term(seg_accel[c], t0));
        r.speed_out = clamp32(longint'(v0) + scale_q16(seg_accel[c], t0));
        r.segment_index = SEG_OUT_W'(c);
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR: %s got %h expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Request driver.
  always @(posedge clk) begin
    bit busy;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        expected_results = {expected_results, profile_step(in_data)};
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          in_data <= pending_requests.pop_front();
          in_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall.
  always @(posedge clk) begin
    out_item_t want;
    int p;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_data), '0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
          if (out_data.angle_out !== want.angle_out)
            report_mismatch("angle_out", out_data.angle_out, want.angle_out);
          if (out_data.speed_out !== want.speed_out)
            report_mismatch("speed_out", out_data.speed_out, want.speed_out);
          if (out_data.segment_index !== want.segment_index)
            report_mismatch("segment_index", 32'(out_data.segment_index),
                            32'(want.segment_index));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        p = $urandom_range(0, 99);
        if (calm || p < 65) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          stall_left = p < 95 ? $urandom_range(0, 2) : $urandom_range(15, 50);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic queue_add(logic [31:0] dur, logic [31:0] acc);
    in_item_t it;
    logic [32:0] sum;
    it = '0;
    it.command = CMD_ADD;
    it.seg_duration = dur;
    it.seg_accel = acc;
    it.query_time = $urandom();
    pending_requests = {pending_requests, it};
    if (plan_bounds.size() < MAX_SEGMENTS) begin
      sum = {1'b0, plan_total} + {1'b0, dur};
      plan_total = sum[32] ? 32'hFFFFFFFF : sum[31:0];
      plan_bounds = {plan_bounds, plan_total};
    end
  endtask

  task automatic queue_query(logic [31:0] t);
    in_item_t it;
    it.command = CMD_QUERY;
    it.seg_duration = $urandom();
    it.seg_accel = $urandom();
    it.query_time = t;
    pending_requests = {pending_requests, it};
  endtask

  task automatic queue_random();
    int p;
    logic [31:0] b, dur, acc;
    if ($urandom_range(0, 99) < 8) begin
      p = $urandom_range(0, 99);
      dur = p < 2 ? $urandom() : (p < 8 ? 32'd0 : $urandom_range(1, 32'h60000));
      p = $urandom_range(0, 99);
      acc = p < 20 ? $urandom() : (p < 30 ? 32'd0 : 32'($signed($urandom_range(0, 32'h80000))
            - 32'sh40000));
      queue_add(dur, acc);
    end else begin
      p = $urandom_range(0, 99);
      if (p < 40 && plan_bounds.size() > 0) begin
        b = plan_bounds[$urandom_range(0, plan_bounds.size() - 1)];
        queue_query(b + 32'($signed($urandom_range(0, 2)) - 1));
      end else if (p < 88) begin
        queue_query(plan_total == 0 ? 32'd0 : $urandom_range(0, plan_total));
      end else begin
        queue_query($urandom());
      end
    end
  endtask

  // Blocks until every request has been sent and answered, then lets the block settle.
  task automatic drain();
    do @(posedge clk);
    while (pending_requests.size() > 0 || in_valid || expected_results.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_START_ANGLE: cfg_angle0 = val;
      CFG_START_SPEED: cfg_speed0 = val;
      CFG_SPEED_EPS: cfg_eps = val[30:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Empty table: queries report the start registers as past the end.
    queue_query(32'd0);
    queue_query(32'hFFFFFFFF);
    drain();
    write_reg(CFG_START_ANGLE, 32'h7FFFFFFF);
    write_reg(CFG_START_SPEED, 32'h80000000);
    write_reg(CFG_SPEED_EPS, 32'h7FFFFFFF);
    queue_query(32'h1234);
    drain();
    write_reg(CFG_START_ANGLE, 32'h80000000);
    write_reg(CFG_START_SPEED, 32'h7FFFFFFF);
    write_reg(CFG_SPEED_EPS, 32'h0);
    queue_query(32'd0);
    drain();
    write_reg(CFG_START_ANGLE, 32'h0003_0000);
    write_reg(CFG_START_SPEED, 32'hFFFF_0000);
    write_reg(CFG_SPEED_EPS, 32'h0000_0800);

    // Directed segments: zero length, extreme accelerations, saturating angle.
    queue_add(32'd0, 32'd0);
    queue_add(32'h0001_0000, 32'h7FFFFFFF);
    queue_query(32'h0000_8000);
    queue_query(32'h0001_0000);
    queue_add(32'h0002_0000, 32'h80000000);
    queue_query(32'h0002_0000);
    queue_query(32'h0001_8000);
    queue_query(32'h0000_0001);
    queue_query(32'h0003_0000);
    queue_add(32'h0000_0000, 32'h0001_0000);
    queue_add(32'h0001_0000, 32'h0000_0800);
    queue_query(32'h0003_0000);
    queue_query(32'h0003_0001);
    queue_query(32'h0000_4000);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      calm = (ph == 2);
      write_reg(CFG_START_ANGLE, $urandom());
      write_reg(CFG_START_SPEED, ph == 3 ? 32'h80000000 : $urandom());
      write_reg(CFG_SPEED_EPS, ph == 4 ? 32'h7FFFFFFF : $urandom_range(0, 32'h4000));
      for (int i = 0; i < 300; i++) queue_random();
      drain();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/prmp_pkg.sv
sv/prmp_ctrl.sv
sv/prmp_dp.sv
sv/piecewise_ramp_motion_profile.sv
sv/prmp_chk.sv
test/piecewise_ramp_motion_profile_tb.sv
